### rtl/core/csv_record_field_splitter_macros.svh
// Assertion macros for the CSV record field splitter.
// Used at the end of the top level; expects clk and arst_n in scope.
`ifndef CSV_RECORD_FIELD_SPLITTER_MACROS_SVH
`define CSV_RECORD_FIELD_SPLITTER_MACROS_SVH

// same-cycle implication
`define CSV_RFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSV_RFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/csv_rfs_pkg.sv
// Shared types and constants for the CSV record field splitter.
// No dependencies.
package csv_rfs_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FIELD_CAP = 2'd1;
	localparam logic [1:0] ST_ROW_CAP   = 2'd2;
	localparam logic [1:0] ST_HALTED    = 2'd3;

	localparam logic [1:0] CFG_FIELD_LIMIT = 2'd0;
	localparam logic [1:0] CFG_ROW_LIMIT   = 2'd1;

	typedef enum logic [7:0] {
		M_ROW_START   = 8'b0000_0001,
		M_FIELD_START = 8'b0000_0010,
		M_UNQUOTED    = 8'b0000_0100,
		M_QUOTED      = 8'b0000_1000,
		M_QUOTE_SEEN  = 8'b0001_0000,
		M_AFTER_CLOSE = 8'b0010_0000,
		M_SKIP_ROW    = 8'b0100_0000,
		M_HALTED      = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  content_byte;
		logic        field_done;
		logic        row_done;
		logic [15:0] field_number;
		logic [1:0]  status;
		logic        last_of_run;
	} result_t;

	// parser to top: words produced by the current byte, halt flag
	typedef struct packed {
		logic [1:0] npush;
		logic       halted;
	} psr_stat_t;

endpackage

### rtl/core/csv_record_field_splitter.sv
// CSV record field splitter: raw CSV bytes in, unescaped field bytes and
// field/row end marks out. Depends on csv_rfs_pkg, csv_rfs_parser,
// csv_rfs_resq and csv_record_field_splitter_macros.svh.
//
// Input channel (in_valid/in_ready) takes one text byte per word with an
// end_of_input flag. Output channel (out_valid/out_ready) gives result words;
// a byte makes zero, one or two of them, the final one marked last_of_run.
// Config channel (cfg_valid/cfg_ready, always ready) writes field_limit
// (index 0) and row_limit (index 1); write only while the block is idle.
// Path: a byte is registered, then parsed once the result queue has room,
// and its results are written into the result queue that drives the output.
// Throughput: one byte per cycle while results are drained; the parse step
// needs two free queue slots, so bytes that make two results take two
// words of output bandwidth at the drain side.
// Reset clears parser state, queue and limits (no limit).
// When the receiver stalls, the queue fills and in_ready drops once fewer
// than two slots are free; nothing is lost.
`include "csv_record_field_splitter_macros.svh"

module csv_record_field_splitter #(
	parameter int RES_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_byte,
	output logic [7:0]  content_byte,
	output logic        field_done,
	output logic        row_done,
	output logic [15:0] field_number,
	output logic [1:0]  status,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import csv_rfs_pkg::*;

	localparam int CW = $clog2(RES_DEPTH + 1);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic [15:0] field_limit_q;
	logic [31:0] row_limit_q;
	logic        fire, room;
	logic [1:0]  push_cnt;
	logic [CW-1:0] occ;
	result_t     res0, res1, rd;
	psr_stat_t   psr_stat;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign in_ready  = !valid_s1 || fire;
	assign push_cnt  = fire ? psr_stat.npush : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_limit_q <= 16'd0;
			row_limit_q   <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIELD_LIMIT: field_limit_q <= cfg_data[15:0];
				CFG_ROW_LIMIT:   row_limit_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			eof_s1  <= end_of_input;
		end
	end

	csv_rfs_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.byte_in     (byte_s1),
		.eof_in      (eof_s1),
		.field_limit (field_limit_q),
		.row_limit   (row_limit_q),
		.res0        (res0),
		.res1        (res1),
		.stat        (psr_stat)
	);

	csv_rfs_resq #(
		.DEPTH (RES_DEPTH)
	) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.wr0       (res0),
		.wr1       (res1),
		.room      (room),
		.occupancy (occ),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rd_data   (rd)
	);

	assign has_byte     = rd.has_byte;
	assign content_byte = rd.content_byte;
	assign field_done   = rd.field_done;
	assign row_done     = rd.row_done;
	assign field_number = rd.field_number;
	assign status       = rd.status;
	assign last_of_run  = rd.last_of_run;

	`CSV_RFS_ASSERT_NOW(a_two_words_last, fire && psr_stat.npush == 2'd2, !res0.last_of_run && res1.last_of_run, "only the second of two words may be last")
	`CSV_RFS_ASSERT_NOW(a_queue_bound, 1'b1, occ <= CW'(RES_DEPTH), "result queue overflow")
	`CSV_RFS_ASSERT_NOW(a_halted_word, fire && psr_stat.halted, psr_stat.npush == 2'd1 && res0.status == ST_HALTED, "halted byte must give one halted word")
	`CSV_RFS_ASSERT_NEXT(a_row_cap_halts, fire && !eof_s1 && psr_stat.npush != 2'd0 && res0.status == ST_ROW_CAP, psr_stat.halted, "row cap did not halt parser")

endmodule

### rtl/core/csv_rfs_parser.sv
// Parser state and combinational byte step: up to two result words per byte.
// Depends on csv_rfs_pkg.
module csv_rfs_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            byte_in,
	input  logic                  eof_in,
	input  logic [15:0]           field_limit,
	input  logic [31:0]           row_limit,
	output csv_rfs_pkg::result_t  res0,
	output csv_rfs_pkg::result_t  res1,
	output csv_rfs_pkg::psr_stat_t stat
);
	import csv_rfs_pkg::*;

	mode_t       mode_q, mode_d;
	logic [15:0] fir_q, fir_d;
	logic [31:0] rows_q, rows_d;

	always_comb begin
		mode_t       mode1, mode2;
		logic [15:0] fir1, fir2;
		logic [31:0] rows1;
		logic        is_line, is_term, is_comma, is_quote;
		logic        do_term, do_rowend, rowend_fd, row_cap, va, vb;
		result_t     ra, rb;

		is_comma = (byte_in == CH_COMMA);
		is_quote = (byte_in == CH_QUOTE);
		is_line  = (byte_in == CH_CR) || (byte_in == CH_LF);
		is_term  = is_comma || is_line;

		mode1 = mode_q;
		fir1  = fir_q;
		rows1 = rows_q;
		if (mode_q == M_ROW_START && !is_line) begin
			rows1 = (rows_q != 32'hFFFF_FFFF) ? rows_q + 32'd1 : rows_q;
			fir1  = 16'd1;
			mode1 = M_FIELD_START;
		end

		mode2     = mode1;
		fir2      = fir1;
		do_term   = 1'b0;
		do_rowend = 1'b0;
		rowend_fd = 1'b0;
		va        = 1'b0;
		ra        = '0;

		case (mode1)
			M_FIELD_START: begin
				if (is_quote) begin
					mode2 = M_QUOTED;
				end else if (is_term) begin
					do_term = 1'b1;
				end else begin
					va          = 1'b1;
					ra.has_byte = 1'b1;
					mode2       = M_UNQUOTED;
				end
			end
			M_UNQUOTED: begin
				if (is_term) begin
					do_term = 1'b1;
				end else begin
					va          = 1'b1;
					ra.has_byte = 1'b1;
				end
			end
			M_QUOTED: begin
				if (is_quote) begin
					mode2 = M_QUOTE_SEEN;
				end else begin
					va          = 1'b1;
					ra.has_byte = 1'b1;
				end
			end
			M_QUOTE_SEEN: begin
				if (is_quote) begin
					va          = 1'b1;
					ra.has_byte = 1'b1;
					mode2       = M_QUOTED;
				end else if (is_term) begin
					do_term = 1'b1;
				end else begin
					mode2 = M_AFTER_CLOSE;
				end
			end
			M_AFTER_CLOSE: begin
				if (is_term) begin
					do_term = 1'b1;
				end
			end
			M_SKIP_ROW: begin
				if (is_line) begin
					do_rowend = 1'b1;
				end
			end
			M_HALTED: begin
				va        = 1'b1;
				ra.status = ST_HALTED;
			end
			default: begin
			end
		endcase

		if (do_term) begin
			if (is_comma) begin
				va            = 1'b1;
				ra.field_done = 1'b1;
				if (field_limit != 16'd0 && fir1 >= field_limit) begin
					ra.status = ST_FIELD_CAP;
					mode2     = M_SKIP_ROW;
				end else begin
					fir2  = (fir1 != 16'hFFFF) ? fir1 + 16'd1 : fir1;
					mode2 = M_FIELD_START;
				end
			end else begin
				do_rowend = 1'b1;
				rowend_fd = 1'b1;
			end
		end

		row_cap = (row_limit != 32'd0) && (rows1 >= row_limit);
		if (do_rowend) begin
			va            = 1'b1;
			ra.field_done = rowend_fd;
			ra.row_done   = 1'b1;
			ra.status     = row_cap ? ST_ROW_CAP : ST_OK;
			mode2         = row_cap ? M_HALTED : M_ROW_START;
		end

		ra.content_byte = ra.has_byte ? byte_in : 8'd0;
		ra.field_number = (mode1 != M_HALTED && fir1 != 16'd0) ? fir1 - 16'd1 : 16'd0;

		// end of input closes an open field or a dropped row
		vb = eof_in && (mode2 != M_ROW_START) && (mode2 != M_HALTED);
		rb              = '0;
		rb.field_done   = (mode2 != M_SKIP_ROW);
		rb.row_done     = 1'b1;
		rb.status       = ST_OK;
		rb.field_number = (fir2 != 16'd0) ? fir2 - 16'd1 : 16'd0;
		rb.last_of_run  = 1'b1;
		ra.last_of_run  = !vb;

		res0 = va ? ra : rb;
		res1 = rb;
		stat.npush  = {1'b0, va} + {1'b0, vb};
		stat.halted = (mode_q == M_HALTED);

		if (eof_in) begin
			mode_d = M_ROW_START;
			fir_d  = 16'd0;
			rows_d = 32'd0;
		end else begin
			mode_d = mode2;
			fir_d  = fir2;
			rows_d = rows1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_ROW_START;
			fir_q  <= 16'd0;
			rows_q <= 32'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			fir_q  <= fir_d;
			rows_q <= rows_d;
		end
	end

endmodule

### rtl/core/csv_rfs_resq.sv
// Result queue: takes up to two words per cycle, gives one per cycle while out_ready is high.
// Depends on csv_rfs_pkg.
module csv_rfs_resq #(
	parameter int DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  push_cnt,
	input  csv_rfs_pkg::result_t        wr0,
	input  csv_rfs_pkg::result_t        wr1,
	output logic                        room,
	output logic [$clog2(DEPTH+1)-1:0]  occupancy,
	output logic                        out_valid,
	input  logic                        out_ready,
	output csv_rfs_pkg::result_t        rd_data
);
	import csv_rfs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t        mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q, wp1, wp2, rp1;
	logic [CW-1:0]  cnt_q;
	logic           pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wp1       = ptr_inc(wp_q);
	assign wp2       = ptr_inc(wp1);
	assign rp1       = ptr_inc(rp_q);
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign rd_data   = mem_q[rp_q];
	assign room      = (cnt_q <= CW'(DEPTH - 2));
	assign occupancy = cnt_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wp_q] <= wr0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wp1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (push_cnt)
				2'd1:    wp_q <= wp1;
				2'd2:    wp_q <= wp2;
				default: wp_q <= wp_q;
			endcase
			if (pop) begin
				rp_q <= rp1;
			end
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

### tb/csv_record_field_splitter_tb.sv
// Self-checking testbench for csv_record_field_splitter: CSV text bytes in,
// field bytes and field/row end marks out, checked against a byte-level parser.
// Depends on csv_rfs_pkg and the RTL of the block.
import csv_rfs_pkg::*;

typedef logic [7:0] text_q_t[$];

class split_checker;
	result_t expected_words[$];
	result_t step_words[$];
	mode_t       mode;
	logic        after_cr;
	logic [15:0] fields;
	logic [31:0] rows;
	logic [15:0] field_lim;
	logic [31:0] row_lim;
	int errors;
	int bytes_in;
	int words_checked;
	int field_caps;
	int row_caps;
	int halted_words;

	function new();
		mode = M_ROW_START;
		after_cr = 1'b0;
		fields = '0;
		rows = '0;
		field_lim = '0;
		row_lim = '0;
		errors = 0;
		bytes_in = 0;
		words_checked = 0;
		field_caps = 0;
		row_caps = 0;
		halted_words = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] data);
		if (idx == CFG_FIELD_LIMIT)
			field_lim = data[15:0];
		else if (idx == CFG_ROW_LIMIT)
			row_lim = data;
	endfunction

	function int pending();
		return expected_words.size();
	endfunction

	function void emit(logic has, logic [7:0] b, logic fd, logic rd, logic [1:0] st);
		result_t r;
		r.has_byte = has;
		r.content_byte = b;
		r.field_done = fd;
		r.row_done = rd;
		r.field_number = (mode != M_HALTED && fields != 0) ? fields - 16'd1 : 16'd0;
		r.status = st;
		r.last_of_run = 1'b0;
		step_words.push_back(r);
	endfunction

	function void end_row(logic fd);
		logic [1:0] st;
		st = (row_lim != 0 && rows >= row_lim) ? ST_ROW_CAP : ST_OK;
		emit(1'b0, 8'h00, fd, 1'b1, st);
		mode = (st == ST_ROW_CAP) ? M_HALTED : M_ROW_START;
	endfunction

	function void end_field(logic [7:0] b);
		if (b != CH_COMMA) begin
			end_row(1'b1);
		end else if (field_lim != 0 && fields >= field_lim) begin
			emit(1'b0, 8'h00, 1'b1, 1'b0, ST_FIELD_CAP);
			mode = M_SKIP_ROW;
		end else begin
			emit(1'b0, 8'h00, 1'b1, 1'b0, ST_OK);
			if (fields != 16'hFFFF)
				fields++;
			mode = M_FIELD_START;
		end
	endfunction

	// one accepted text word: predict the result words it causes
	function void note_byte(logic [7:0] b, logic eoi);
		logic term;
		logic line;
		term = (b == CH_COMMA) || (b == CH_CR) || (b == CH_LF);
		line = (b == CH_CR) || (b == CH_LF);
		bytes_in++;
		step_words.delete();
		if (mode == M_HALTED) begin
			emit(1'b0, 8'h00, 1'b0, 1'b0, ST_HALTED);
		end else begin
			if (mode == M_ROW_START && !line) begin
				if (rows != 32'hFFFF_FFFF)
					rows++;
				fields = 16'd1;
				mode = M_FIELD_START;
			end
			case (mode)
				M_FIELD_START: begin
					if (b == CH_QUOTE)
						mode = M_QUOTED;
					else if (term)
						end_field(b);
					else begin
						emit(1'b1, b, 1'b0, 1'b0, ST_OK);
						mode = M_UNQUOTED;
					end
				end
				M_UNQUOTED: begin
					if (term)
						end_field(b);
					else
						emit(1'b1, b, 1'b0, 1'b0, ST_OK);
				end
				M_QUOTED: begin
					if (b == CH_QUOTE)
						mode = M_QUOTE_SEEN;
					else
						emit(1'b1, b, 1'b0, 1'b0, ST_OK);
				end
				M_QUOTE_SEEN: begin
					if (b == CH_QUOTE) begin
						emit(1'b1, CH_QUOTE, 1'b0, 1'b0, ST_OK);
						mode = M_QUOTED;
					end else if (term)
						end_field(b);
					else
						mode = M_AFTER_CLOSE;
				end
				M_AFTER_CLOSE: begin
					if (term)
						end_field(b);
				end
				M_SKIP_ROW: begin
					if (line)
						end_row(1'b0);
				end
				default: ;
			endcase
		end
		after_cr = (b == CH_CR) && (mode == M_ROW_START);
		if (eoi) begin
			if (mode inside {M_FIELD_START, M_UNQUOTED, M_QUOTED, M_QUOTE_SEEN, M_AFTER_CLOSE})
				emit(1'b0, 8'h00, 1'b1, 1'b1, ST_OK);
			else if (mode == M_SKIP_ROW)
				emit(1'b0, 8'h00, 1'b0, 1'b1, ST_OK);
			mode = M_ROW_START;
			after_cr = 1'b0;
			fields = '0;
			rows = '0;
		end
		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last_of_run = 1'b1;
		foreach (step_words[i])
			expected_words.push_back(step_words[i]);
	endfunction

	function void cmp(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			errors++;
			if (errors <= 30)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
		end
	endfunction

	function void check_word(result_t got);
		result_t exp;
		if (expected_words.size() == 0) begin
			errors++;
			if (errors <= 30)
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
			return;
		end
		exp = expected_words.pop_front();
		words_checked++;
		if (got.status == ST_FIELD_CAP)
			field_caps++;
		if (got.status == ST_ROW_CAP)
			row_caps++;
		if (got.status == ST_HALTED)
			halted_words++;
		cmp("has_byte", exp.has_byte, got.has_byte);
		cmp("content_byte", exp.content_byte, got.content_byte);
		cmp("field_done", exp.field_done, got.field_done);
		cmp("row_done", exp.row_done, got.row_done);
		cmp("field_number", exp.field_number, got.field_number);
		cmp("status", exp.status, got.status);
		cmp("last_of_run", exp.last_of_run, got.last_of_run);
	endfunction
endclass

module csv_record_field_splitter_tb;
	localparam int STALL_LIMIT = 2000;
	localparam logic [31:0] FIELD_LIMITS [9] = '{0, 1, 65535, 3, 2, 0, 65535, 1, 4};
	localparam logic [31:0] ROW_LIMITS [9] = '{0, 1, 32'hFFFF_FFFF, 3, 0, 2, 1, 5, 0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        has_byte;
	logic [7:0]  content_byte;
	logic        field_done;
	logic        row_done;
	logic [15:0] field_number;
	logic [1:0]  status;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_FIELD_LIMIT;
	logic [31:0] cfg_data = '0;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int stuck_cycles = 0;
	split_checker sb = new();

	csv_record_field_splitter u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_word({has_byte, content_byte, field_done, row_done, field_number,
				status, last_of_run});

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [7:0] special_byte();
		case ($urandom_range(0, 3))
			0: return CH_QUOTE;
			1: return CH_COMMA;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	function automatic void add_eol(ref text_q_t d);
		case ($urandom_range(0, 2))
			0: d.push_back(CH_CR);
			1: d.push_back(CH_LF);
			default: begin
				d.push_back(CH_CR);
				d.push_back(CH_LF);
			end
		endcase
	endfunction

	// random rows: plain, quoted and raw-byte fields, some with junk after a closing quote
	function automatic text_q_t csv_doc();
		text_q_t d;
		int n_rows;
		int n_fields;
		int len;
		logic [7:0] c;
		n_rows = $urandom_range(1, 4);
		for (int r = 0; r < n_rows; r++) begin
			if ($urandom_range(0, 9) == 0)
				add_eol(d);
			n_fields = $urandom_range(1, 5);
			for (int f = 0; f < n_fields; f++) begin
				if (f > 0)
					d.push_back(CH_COMMA);
				len = $urandom_range(0, 4);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						for (int i = 0; i < len; i++)
							d.push_back(plain_byte());
					end
					9: begin
						for (int i = 0; i < len; i++)
							d.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						d.push_back(CH_QUOTE);
						for (int i = 0; i < len; i++) begin
							c = ($urandom_range(0, 3) == 0) ? special_byte()
								: 8'($urandom_range(0, 255));
							d.push_back(c);
							if (c == CH_QUOTE)
								d.push_back(CH_QUOTE);
						end
						d.push_back(CH_QUOTE);
						if ($urandom_range(0, 4) == 0)
							d.push_back(plain_byte());
					end
				endcase
			end
			if (r < n_rows - 1 || $urandom_range(0, 1) == 1)
				add_eol(d);
		end
		return d;
	endfunction

	function automatic text_q_t noise_doc();
		text_q_t d;
		int len;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			d.push_back(($urandom_range(0, 2) == 0) ? special_byte()
				: 8'($urandom_range(0, 255)));
		return d;
	endfunction

	// returns at a falling edge with in_valid still high
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b, eoi);
		@(negedge clk);
	endtask

	task automatic send_doc(input text_q_t d, input logic eoi_last);
		foreach (d[i])
			send_byte(d[i], eoi_last && (i == d.size() - 1));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	// quiet point for register writes: words that cause no result may still be in flight
	task automatic settle();
		drain();
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		text_q_t doc;
		int start;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// quoting, doubled quote, junk after close, specials inside quotes,
		// CRLF, empty line, unclosed quote closed at end of input
		doc = {8'h00, CH_COMMA, CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_CR, CH_COMMA,
			CH_LF, CH_QUOTE, 8'h6A, CH_COMMA, 8'hFF, CH_CR, CH_LF, CH_LF, CH_QUOTE, 8'h78};
		send_doc(doc, 1'b1);
		settle();
		write_reg(CFG_FIELD_LIMIT, 32'd1);
		write_reg(CFG_ROW_LIMIT, 32'd1);
		// field cap, row cap and halt, halt left by end of input, dropped row at end
		doc = {8'h61, CH_COMMA, 8'h62, CH_CR, 8'h7A};
		send_doc(doc, 1'b0);
		send_byte(8'h71, 1'b1);
		doc = {8'h61, CH_COMMA, 8'h62};
		send_doc(doc, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			in_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 69 : 0;
			out_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 26 : 0;
			for (int k = 0; k < 3; k++) begin
				settle();
				write_reg(CFG_FIELD_LIMIT, FIELD_LIMITS[phase * 3 + k]);
				write_reg(CFG_ROW_LIMIT, ROW_LIMITS[phase * 3 + k]);
				start = sb.bytes_in;
				while (sb.bytes_in - start < 110) begin
					doc = ($urandom_range(0, 6) == 0) ? noise_doc() : csv_doc();
					send_doc(doc, 1'b1);
					if ($urandom_range(0, 7) == 0)
						drain();
				end
			end
		end

		drain();
		repeat (10) @(negedge clk);
		$display("%0d text words sent, %0d result words checked over 9 limit settings",
			sb.bytes_in, sb.words_checked);
		$display("field caps %0d, row caps %0d, words while halted %0d",
			sb.field_caps, sb.row_caps, sb.halted_words);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
